@@ design/wts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

    localparam int TEMPLATE_DEPTH_DEF = 64;
    localparam int RESULT_DEPTH_DEF   = 32;

    localparam int LEN_W   = 7;
    localparam int CAP_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 7;

    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REARM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    localparam logic CFG_LENGTH   = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    localparam logic [BYTE_W-1:0] ENT_SKIP_UNTIL = 8'hfc;
    localparam logic [BYTE_W-1:0] ENT_SKIP_ONE   = 8'hfd;
    localparam logic [BYTE_W-1:0] ENT_CAP_ONE    = 8'hfe;
    localparam logic [BYTE_W-1:0] ENT_CAP_UNTIL  = 8'hff;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_REARM,
        OP_WRITE,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SKIP_UNTIL,
        ACT_SKIP_ONE,
        ACT_CAP_ONE,
        ACT_CAP_UNTIL
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_QUIET,
        ST_FIRE0,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/wts_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wts_front #(
    parameter int TEMPLATE_DEPTH = wts_pkg::TEMPLATE_DEPTH_DEF
) (
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [15:0]                  s_tdata,   // data_byte, template_index
    input  wire logic [wts_pkg::MODE_W-1:0]   s_tuser,   // mode
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output wts_pkg::cmd_t                     push_cmd
);
    import wts_pkg::*;

    logic [INDEX_W-1:0] index;
    logic               index_ok;

    assign index    = s_tdata[BYTE_W +: INDEX_W];
    assign index_ok = 9'(index) < 9'(TEMPLATE_DEPTH);

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_cmd.data  = s_tdata[BYTE_W-1:0];
        push_cmd.index = index;
        unique case (s_tuser)
            MODE_BYTE:  push_cmd.op = OP_BYTE;
            MODE_REARM: push_cmd.op = OP_REARM;
            MODE_WRITE: push_cmd.op = index_ok ? OP_WRITE : OP_NOP;
            default:    push_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

@@ design/wts_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wts_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire wts_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output wts_pkg::cmd_t      out_cmd
);
    import wts_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/wts_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wts_back #(
    parameter int TEMPLATE_DEPTH = wts_pkg::TEMPLATE_DEPTH_DEF,
    parameter int RESULT_DEPTH   = wts_pkg::RESULT_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire wts_pkg::cmd_t              cmd,
    input  wire logic [wts_pkg::LEN_W-1:0]  len,
    input  wire logic [wts_pkg::CAP_W-1:0]  cap,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,   // capture_count, capture_byte
    output logic [0:0]                      m_tuser,   // fired
    output logic                            m_tlast
);
    import wts_pkg::*;

    localparam int AW = $clog2(TEMPLATE_DEPTH);
    localparam int CW = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;

    logic [BYTE_W-1:0] tmem [TEMPLATE_DEPTH];
    logic [BYTE_W-1:0] cmem [RESULT_DEPTH];

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    act_t              pend_reg, pend_next;
    logic [BYTE_W-1:0] term_reg, term_next;
    logic              done_reg, done_next;
    logic [CAP_W-1:0]  total_reg, total_next;
    logic [CAP_W-1:0]  k_reg, k_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BYTE_W-1:0] trd_reg;
    logic [BYTE_W-1:0] crd_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic              fired_reg, fired_next;
    logic [CAP_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] cbyte_reg, cbyte_next;
    logic              last_reg, last_next;

    // EXEC results
    logic [LEN_W-1:0]  pos_x;
    act_t              pend_x;
    logic [BYTE_W-1:0] term_x;
    logic [CAP_W-1:0]  total_x;
    logic              cap_we;
    logic              fire_x;

    logic              out_free, out_load;
    logic              tmem_we;
    logic [6:0]        lim;
    logic              can_cap;
    logic              emit_last;
    logic              idle_skip;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cmd_ready = state_reg == ST_IDLE;
    assign lim       = ({1'b0, cap} < 7'(RESULT_DEPTH)) ? {1'b0, cap} : 7'(RESULT_DEPTH);
    assign can_cap   = {1'b0, total_reg} < lim;
    assign emit_last = (k_reg + 6'd1) == total_reg;
    assign idle_skip = done_reg || (pos_reg > len);

    // action on the current byte
    always_comb begin
        pos_x   = pos_reg;
        pend_x  = pend_reg;
        term_x  = term_reg;
        total_x = total_reg;
        cap_we  = 1'b0;
        case (pend_reg)
            ACT_CAP_UNTIL: begin
                if (byte_reg == term_reg) begin
                    pend_x = ACT_NONE;
                    term_x = '0;
                end else begin
                    cap_we = can_cap;
                end
            end
            ACT_CAP_ONE: begin
                cap_we = can_cap;
                pend_x = ACT_NONE;
                term_x = '0;
            end
            ACT_SKIP_ONE: begin
                pend_x = ACT_NONE;
                term_x = '0;
            end
            ACT_SKIP_UNTIL: begin
                if (byte_reg == term_reg) begin
                    pend_x = ACT_NONE;
                    term_x = '0;
                end
            end
            default: begin
                if (byte_reg != term_reg) begin
                    pos_x   = '0;
                    total_x = '0;
                end
            end
        endcase
        if (cap_we) begin
            total_x = total_reg + 6'd1;
        end
        fire_x = (pos_x >= len) && (pend_x == ACT_NONE);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.op == OP_BYTE && !idle_skip) begin
                        state_next = (pend_reg != ACT_NONE) ? ST_EXEC : ST_FETCH;
                    end else begin
                        state_next = ST_QUIET;
                    end
                end
            end
            ST_FETCH:   state_next = (pos_reg < len) ? ST_DECODE : ST_QUIET;
            ST_DECODE: begin
                if (trd_reg == ENT_SKIP_UNTIL || trd_reg == ENT_CAP_UNTIL) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!fire_x) begin
                    state_next = ST_QUIET;
                end else begin
                    state_next = (total_x == '0) ? ST_FIRE0 : ST_EMIT_RD;
                end
            end
            ST_QUIET:   state_next = out_free ? ST_IDLE : ST_QUIET;
            ST_FIRE0:   state_next = out_free ? ST_IDLE : ST_FIRE0;
            ST_EMIT_RD: state_next = ST_EMIT_WR;
            ST_EMIT_WR: begin
                if (out_free) begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pos_next      = pos_reg;
        pend_next     = pend_reg;
        term_next     = term_reg;
        done_next     = done_reg;
        total_next    = total_reg;
        k_next        = k_reg;
        byte_next     = byte_reg;
        tmem_we       = 1'b0;
        out_load      = 1'b0;
        fired_next    = fired_reg;
        count_next    = count_reg;
        cbyte_next    = cbyte_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    byte_next = cmd.data;
                    if (cmd.op == OP_REARM) begin
                        pos_next   = '0;
                        pend_next  = ACT_NONE;
                        term_next  = '0;
                        done_next  = 1'b0;
                        total_next = '0;
                    end
                    tmem_we = cmd.op == OP_WRITE;
                end
            end
            ST_DECODE: begin
                pos_next = pos_reg + 7'd1;
                unique case (trd_reg)
                    ENT_SKIP_UNTIL: begin
                        pend_next = ACT_SKIP_UNTIL;
                        term_next = '0;
                    end
                    ENT_CAP_UNTIL: begin
                        pend_next = ACT_CAP_UNTIL;
                        term_next = '0;
                    end
                    ENT_SKIP_ONE: begin
                        pend_next = ACT_SKIP_ONE;
                        term_next = '0;
                    end
                    ENT_CAP_ONE: begin
                        pend_next = ACT_CAP_ONE;
                        term_next = '0;
                    end
                    default: term_next = trd_reg;
                endcase
            end
            ST_EXEC: begin
                pos_next   = pos_x;
                pend_next  = pend_x;
                term_next  = term_x;
                total_next = total_x;
                k_next     = '0;
                if (fire_x) begin
                    done_next = 1'b1;
                end
            end
            ST_QUIET, ST_FIRE0: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    fired_next = state_reg == ST_FIRE0;
                    count_next = '0;
                    cbyte_next = '0;
                    last_next  = 1'b1;
                end
            end
            ST_EMIT_WR: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    fired_next = 1'b1;
                    count_next = total_reg;
                    cbyte_next = crd_reg;
                    last_next  = emit_last;
                    k_next     = k_reg + 6'd1;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            pend_reg     <= ACT_NONE;
            term_reg     <= '0;
            done_reg     <= 1'b0;
            total_reg    <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            pend_reg     <= pend_next;
            term_reg     <= term_next;
            done_reg     <= done_next;
            total_reg    <= total_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        fired_reg <= fired_next;
        count_reg <= count_next;
        cbyte_reg <= cbyte_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (tmem_we) begin
            tmem[AW'(cmd.index)] <= cmd.data;
        end
        trd_reg <= tmem[AW'(pos_reg)];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC && cap_we) begin
            cmem[CW'(total_reg)] <= byte_reg;
        end
        crd_reg <= cmem[CW'(k_reg)];
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {2'b00, cbyte_reg, count_reg};
    assign m_tuser[0] = fired_reg;
    assign m_tlast    = last_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output word overwritten while stalled");

    a_fire_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> (state_reg == ST_FIRE0 || state_reg == ST_EMIT_RD))
        else $error("match completed without emitting");

    a_decode_after_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECODE) |-> ($past(state_reg) == ST_FETCH))
        else $error("template entry decoded without a fetch");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_WR) |-> (k_reg < total_reg))
        else $error("capture index past captured total");
`endif

endmodule

`default_nettype wire

@@ design/wildcard_template_sniffer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                 Contents (lowest bit up)
// s_        in   s_tdata / s_tuser     data_byte[7:0], template_index[13:8] / mode[1:0]
// m_        out  m_tdata / m_tuser     capture_count[5:0], capture_byte[13:6] / fired
// cfg_      in   cfg_wr_en/addr/data   0 template_length, 1 result_capacity
//
// Re-arm, template write: via a quiet state. Stream byte: fetch and decode states per
// template entry fetched from the template memory (one read port, registered).
// A match emits a word per captured byte (one if none), read from the capture memory.
// A 2-word command queue decouples input from the matcher; output has its own
// register. Synchronous active-low reset; both memories are not cleared.

module wildcard_template_sniffer #(
    parameter int TEMPLATE_DEPTH = wts_pkg::TEMPLATE_DEPTH_DEF,
    parameter int RESULT_DEPTH   = wts_pkg::RESULT_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,   // data_byte, template_index
    input  wire logic [wts_pkg::MODE_W-1:0] s_tuser,   // mode
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,   // capture_count, capture_byte
    output logic [0:0]                      m_tuser,   // fired
    output logic                            m_tlast,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_addr,
    input  wire logic [wts_pkg::CFG_W-1:0]  cfg_wr_data
);
    import wts_pkg::*;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [CAP_W-1:0] cap_reg, cap_next;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    always_comb begin
        len_next = len_reg;
        cap_next = cap_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LENGTH: begin
                    if ({1'b0, cfg_wr_data} > 8'(TEMPLATE_DEPTH)) begin
                        len_next = LEN_W'(TEMPLATE_DEPTH);
                    end else begin
                        len_next = cfg_wr_data;
                    end
                end
                CFG_CAPACITY: cap_next = cfg_wr_data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            cap_reg <= 6'd32;
        end else begin
            len_reg <= len_next;
            cap_reg <= cap_next;
        end
    end

    wts_front #(
        .TEMPLATE_DEPTH(TEMPLATE_DEPTH)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd)
    );

    wts_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_cmd   (push_cmd),
        .out_valid(cmd_valid),
        .out_ready(cmd_ready),
        .out_cmd  (cmd)
    );

    wts_back #(
        .TEMPLATE_DEPTH(TEMPLATE_DEPTH),
        .RESULT_DEPTH  (RESULT_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .len      (len_reg),
        .cap      (cap_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
